// ===== src/cpc_pkg.sv =====
`timescale 1ns / 1ps

package cpc_pkg;

	// Largest number of decimal digits a candidate may have.
	localparam int MAX_DIGITS = 6;

	// Fixed width of the candidate field.
	localparam int CAND_W = 20;

	// Bus widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = ((CAND_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// Candidates at or above this bound are out of range.
	localparam logic [63:0] LIMIT = 64'(10 ** MAX_DIGITS);

	// Width that holds any in-range value and any digit rotation of it.
	localparam int VAL_W = $clog2(10 ** MAX_DIGITS);

	// Trial divisor and its square.
	localparam int D_W  = (VAL_W + 1) / 2 + 1;
	localparam int SQ_W = VAL_W + 2;

	// Packed BCD digits, one nibble each.
	localparam int NIB_W = 4;
	localparam int BCD_W = NIB_W * MAX_DIGITS;

	// Counters.
	localparam int ND_W      = $clog2(MAX_DIGITS + 1);
	localparam int DIV_CNT_W = $clog2(VAL_W + 1);
	localparam int BIN_CNT_W = $clog2(CAND_W + 1);

	// Arithmetic constants.
	localparam int RADIX         = 10;
	localparam int DABBLE_LIMIT  = 5;
	localparam int DABBLE_ADJUST = 3;
	localparam int FIRST_ODD_DIV = 3;
	localparam int DIV_STEP      = 2;

	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} div_status_t;

endpackage

// ===== src/cpc_bcd_conv.sv =====
`timescale 1ns / 1ps

// Binary to packed BCD, one input bit per cycle (shift and add three).
module cpc_bcd_conv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cpc_pkg::CAND_W-1:0]  bin,
	output logic                        done,
	output logic [cpc_pkg::BCD_W-1:0]   bcd
);

	logic                           busy_q;
	logic                           done_q;
	logic [cpc_pkg::BIN_CNT_W-1:0]  cnt_q;
	logic [cpc_pkg::CAND_W-1:0]     bin_q;
	logic [cpc_pkg::BCD_W-1:0]      bcd_q;
	logic [cpc_pkg::BCD_W-1:0]      adj_c;

	always_comb begin
		for (int i = 0; i < cpc_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] >=
			    cpc_pkg::NIB_W'(cpc_pkg::DABBLE_LIMIT)) begin
				adj_c[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] =
					bcd_q[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] +
					cpc_pkg::NIB_W'(cpc_pkg::DABBLE_ADJUST);
			end else begin
				adj_c[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] =
					bcd_q[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= cpc_pkg::BIN_CNT_W'(cpc_pkg::CAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cpc_pkg::BIN_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[cpc_pkg::CAND_W-2:0], 1'b0};
			bcd_q <= {adj_c[cpc_pkg::BCD_W-2:0], bin_q[cpc_pkg::CAND_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== src/cpc_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module cpc_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cpc_pkg::VAL_W-1:0]  dividend,
	input  logic [cpc_pkg::D_W-1:0]    divisor,
	output cpc_pkg::div_status_t       status
);

	logic                           busy_q;
	logic                           done_q;
	logic [cpc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [cpc_pkg::VAL_W-1:0]      num_q;
	logic [cpc_pkg::D_W-1:0]        den_q;
	logic [cpc_pkg::D_W-1:0]        rem_q;
	logic [cpc_pkg::D_W:0]          trial_c;
	logic [cpc_pkg::D_W-1:0]        rem_next_c;

	always_comb begin
		trial_c = {rem_q, num_q[cpc_pkg::VAL_W-1]};
		if (trial_c >= {1'b0, den_q}) begin
			rem_next_c = cpc_pkg::D_W'(trial_c - {1'b0, den_q});
		end else begin
			rem_next_c = trial_c[cpc_pkg::D_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= cpc_pkg::DIV_CNT_W'(cpc_pkg::VAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cpc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[cpc_pkg::VAL_W-2:0], 1'b0};
			rem_q <= rem_next_c;
		end
	end

	assign status.busy     = busy_q;
	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

// ===== src/circular_prime_checker.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_*       in         tdata[19:0] candidate, upper bits unused
// m_*       out        tdata[0] is_circular, upper bits zero
//
// One item at a time. The candidate is first converted to BCD; then each digit
// rotation has its binary value rebuilt from the rotated digits and is tested
// against each odd trial divisor in the bit-serial remainder unit, so the
// worst case is a six-digit circular prime.
// Out-of-range or rejected candidates finish early.
// Reset clears the sequencer and the output valid; no memory needs clearing.
// A finished result waits in the output register while the next item is
// taken; the sequencer only stalls if a second result would overwrite it.
module circular_prime_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cpc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [19:0] candidate
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cpc_pkg::OUT_TDATA_W-1:0] m_tdata    // [0] is_circular
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_BCD    = 3'd1;  // waiting for the BCD conversion
	localparam logic [2:0] S_SCAN   = 3'd2;  // digit count and zero-digit check
	localparam logic [2:0] S_PTEST  = 3'd3;  // trivial primality cases
	localparam logic [2:0] S_PLOOP  = 3'd4;  // next trial divisor or done
	localparam logic [2:0] S_PDIV   = 3'd5;  // waiting for the remainder
	localparam logic [2:0] S_HORNER = 3'd6;  // rebuild binary from rotated digits
	localparam logic [2:0] S_FINISH = 3'd7;  // hand the verdict to the output

	logic [2:0]                     state_q;
	logic [cpc_pkg::VAL_W-1:0]      value_q;
	logic [cpc_pkg::BCD_W-1:0]      bcd_q;
	logic [cpc_pkg::BCD_W-1:0]      conv_q;
	logic [cpc_pkg::VAL_W-1:0]      acc_q;
	logic [cpc_pkg::ND_W-1:0]       ndig_q;
	logic [cpc_pkg::ND_W-1:0]       rot_q;
	logic [cpc_pkg::ND_W-1:0]       hor_cnt_q;
	logic [cpc_pkg::D_W-1:0]        d_q;
	logic [cpc_pkg::SQ_W-1:0]       sq_q;
	logic                           result_q;
	logic                           out_valid_q;
	logic                           out_bit_q;

	logic [cpc_pkg::CAND_W-1:0]     cand_c;
	logic                           accept_c;
	logic                           in_range_c;
	logic                           bcd_start_c;
	logic                           bcd_done;
	logic [cpc_pkg::BCD_W-1:0]      bcd_out;
	logic                           div_start_c;
	cpc_pkg::div_status_t           div_status;
	logic [cpc_pkg::ND_W-1:0]       ndig_c;
	logic                           zero_c;
	logic [cpc_pkg::NIB_W-1:0]      top_c;
	logic [cpc_pkg::BCD_W-1:0]      rot_c;
	logic [cpc_pkg::VAL_W-1:0]      acc_next_c;
	logic                           prime_pass_c;
	logic                           prime_fail_c;
	logic                           out_free_c;

	assign cand_c      = s_tdata[cpc_pkg::CAND_W-1:0];
	assign s_tready    = (state_q == S_IDLE);
	assign accept_c    = s_tvalid && s_tready;
	assign in_range_c  = (64'(cand_c) < cpc_pkg::LIMIT);
	assign bcd_start_c = accept_c && in_range_c;
	assign div_start_c = (state_q == S_PLOOP) && !prime_pass_c;
	assign out_free_c  = !out_valid_q || m_tready;

	cpc_bcd_conv u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start_c),
		.bin    (cand_c),
		.done   (bcd_done),
		.bcd    (bcd_out)
	);

	cpc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_c),
		.dividend (value_q),
		.divisor  (d_q),
		.status   (div_status)
	);

	// Digit count is the position of the highest nonzero digit; a zero
	// anywhere below it rejects the candidate.
	always_comb begin
		ndig_c = '0;
		zero_c = 1'b0;
		for (int i = 0; i < cpc_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] != '0) begin
				ndig_c = cpc_pkg::ND_W'(i + 1);
			end
		end
		for (int i = 0; i < cpc_pkg::MAX_DIGITS; i++) begin
			if (bcd_q[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] == '0 &&
			    cpc_pkg::ND_W'(i) < ndig_c) begin
				zero_c = 1'b1;
			end
		end
	end

	// Left rotation within the significant digits: the leading digit moves
	// to the units place and the rest move up one place.
	always_comb begin
		top_c = '0;
		for (int i = 0; i < cpc_pkg::MAX_DIGITS; i++) begin
			if (cpc_pkg::ND_W'(i + 1) == ndig_q) begin
				top_c = bcd_q[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W];
			end
		end
		rot_c = '0;
		rot_c[cpc_pkg::NIB_W-1:0] = top_c;
		for (int i = 1; i < cpc_pkg::MAX_DIGITS; i++) begin
			if (cpc_pkg::ND_W'(i) < ndig_q) begin
				rot_c[i*cpc_pkg::NIB_W +: cpc_pkg::NIB_W] =
					bcd_q[(i-1)*cpc_pkg::NIB_W +: cpc_pkg::NIB_W];
			end
		end
	end

	// One Horner step: times ten as two shifts, plus the next digit.
	assign acc_next_c = (acc_q << 3) + (acc_q << 1) +
	                    cpc_pkg::VAL_W'(conv_q[cpc_pkg::BCD_W-1 -: cpc_pkg::NIB_W]);

	// Verdict of the current primality test. Two is the only even prime;
	// the loop stops once the divisor squared exceeds the value.
	always_comb begin
		prime_pass_c = 1'b0;
		prime_fail_c = 1'b0;
		if (state_q == S_PTEST) begin
			if (value_q <= cpc_pkg::VAL_W'(1)) begin
				prime_fail_c = 1'b1;
			end else if (value_q == cpc_pkg::VAL_W'(cpc_pkg::DIV_STEP)) begin
				prime_pass_c = 1'b1;
			end else if (!value_q[0]) begin
				prime_fail_c = 1'b1;
			end
		end else if (state_q == S_PLOOP) begin
			prime_pass_c = (sq_q > cpc_pkg::SQ_W'(value_q));
		end else if (state_q == S_PDIV) begin
			prime_fail_c = div_status.done && div_status.rem_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free_c) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			priority if (prime_fail_c) begin
				state_q <= S_FINISH;
			end else if (prime_pass_c) begin
				if (cpc_pkg::ND_W'(rot_q + 1'b1) >= ndig_q) begin
					state_q <= S_FINISH;
				end else begin
					state_q <= S_HORNER;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept_c) begin
							state_q <= in_range_c ? S_BCD : S_FINISH;
						end
					end
					S_BCD: begin
						if (bcd_done) begin
							state_q <= S_SCAN;
						end
					end
					S_SCAN: begin
						state_q <= zero_c ? S_FINISH : S_PTEST;
					end
					S_PTEST: begin
						state_q <= S_PLOOP;
					end
					S_PLOOP: begin
						state_q <= S_PDIV;
					end
					S_PDIV: begin
						if (div_status.done) begin
							state_q <= S_PLOOP;
						end
					end
					S_HORNER: begin
						if (hor_cnt_q == cpc_pkg::ND_W'(1)) begin
							state_q <= S_PTEST;
						end
					end
					S_FINISH: begin
						if (out_free_c) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// Datapath registers follow the same decisions as the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free_c) begin
			out_bit_q <= result_q;
		end

		priority if (prime_fail_c) begin
			result_q <= 1'b0;
		end else if (prime_pass_c) begin
			result_q  <= 1'b1;
			rot_q     <= cpc_pkg::ND_W'(rot_q + 1'b1);
			bcd_q     <= rot_c;
			conv_q    <= rot_c;
			acc_q     <= '0;
			hor_cnt_q <= cpc_pkg::ND_W'(cpc_pkg::MAX_DIGITS);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					result_q <= 1'b0;
					value_q  <= cpc_pkg::VAL_W'(cand_c);
				end
				S_BCD: begin
					if (bcd_done) begin
						bcd_q <= bcd_out;
					end
				end
				S_SCAN: begin
					ndig_q   <= ndig_c;
					rot_q    <= '0;
					result_q <= 1'b0;
				end
				S_PTEST: begin
					d_q  <= cpc_pkg::D_W'(cpc_pkg::FIRST_ODD_DIV);
					sq_q <= cpc_pkg::SQ_W'(cpc_pkg::FIRST_ODD_DIV *
					                       cpc_pkg::FIRST_ODD_DIV);
				end
				S_PDIV: begin
					if (div_status.done) begin
						// (d + 2)^2 = d^2 + 4d + 4
						d_q  <= d_q + cpc_pkg::D_W'(cpc_pkg::DIV_STEP);
						sq_q <= sq_q + (cpc_pkg::SQ_W'(d_q) << 2) + cpc_pkg::SQ_W'(4);
					end
				end
				S_HORNER: begin
					acc_q     <= acc_next_c;
					conv_q    <= conv_q << cpc_pkg::NIB_W;
					hor_cnt_q <= hor_cnt_q - 1'b1;
					if (hor_cnt_q == cpc_pkg::ND_W'(1)) begin
						value_q <= acc_next_c;
					end
				end
				S_PLOOP, S_FINISH: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(cpc_pkg::OUT_TDATA_W-1){1'b0}}, out_bit_q};

	// The divider is only started when it is free.
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_c |-> !div_status.busy)
		else $error("divider started while busy");

	// An out-of-range candidate goes straight to the verdict, and it is zero.
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_c && !in_range_c) |=> (state_q == S_FINISH && !result_q))
		else $error("out-of-range candidate not rejected");

	// The running square always matches the current trial divisor.
	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLOOP) |->
			(sq_q == cpc_pkg::SQ_W'(cpc_pkg::SQ_W'(d_q) * cpc_pkg::SQ_W'(d_q))))
		else $error("divisor square out of step");

	// Trial divisors are always odd.
	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PDIV) |-> d_q[0])
		else $error("even trial divisor");

endmodule
